/* src/gkaq_pkg.sv */
// Package for the grid keypoint area query unit.
// Sizes, field widths, codes and the controller/datapath command and status structs.
// No dependencies.
package gkaq_pkg;

	localparam int MAX_KEYS     = 2048;
	localparam int GRID_COLUMNS = 64;
	localparam int GRID_ROWS    = 48;
	localparam int MAX_HITS     = 64;

	localparam int NUM_CELLS = GRID_COLUMNS * GRID_ROWS;
	localparam int KEY_AW    = $clog2(MAX_KEYS);
	localparam int CNT_W     = $clog2(MAX_KEYS + 1);
	localparam int CELL_AW   = $clog2(NUM_CELLS);
	localparam int HIT_W     = $clog2(MAX_HITS + 1);

	// field widths of the ports
	localparam int FUNC_W     = 2;
	localparam int COORD_W    = 16;
	localparam int LVL_W      = 4;
	localparam int RAD_W      = 15;
	localparam int MAXL_W     = 5;
	localparam int IDX_W      = 11;
	localparam int CIDX_W     = 6;
	localparam int SCALE_W    = 18;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	// fixed point: Q12.4 times Q2.16 gives 20 fraction bits
	localparam int FRAC_BITS = 20;
	localparam int OPND_W    = COORD_W + 2;
	localparam int PROD_W    = 38;
	localparam int EDGE_W    = PROD_W - FRAC_BITS;
	localparam logic [PROD_W-1:0] FRAC_MASK = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);
	localparam logic [PROD_W-1:0] FRAC_HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));

	typedef enum logic [FUNC_W-1:0] {
		FN_CLEAR  = 2'd0,
		FN_INSERT = 2'd1,
		FN_QUERY  = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X  = 2'd0,
		REG_ORIGIN_Y  = 2'd1,
		REG_COL_SCALE = 2'd2,
		REG_ROW_SCALE = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MS_INS_X,
		MS_INS_Y,
		MS_LO_X,
		MS_HI_X,
		MS_LO_Y,
		MS_HI_Y
	} mul_sel_t;

	typedef enum logic [2:0] {
		OS_PLAIN,
		OS_FULL,
		OS_INSERT,
		OS_HIT,
		OS_HIT_LAST,
		OS_HIT_TRUNC
	} out_sel_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [LVL_W-1:0]          lvl;
	} key_ent_t;

	typedef struct packed {
		logic              occ;
		logic [KEY_AW-1:0] first;
		logic [KEY_AW-1:0] tail;
	} cell_ent_t;

	typedef struct packed {
		logic     capture;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     cnt_clr;
		logic     cnt_inc;
		logic     key_wr;
		logic     sweep_wr;
		logic     cell_rd;
		logic     cell_ins_wr;
		logic     ins_load_ix;
		logic     q_load_start;
		logic     ix_inc;
		logic     iy_inc;
		logic     k_load_first;
		logic     k_load_next;
		logic     key_rd;
		logic     hit_rst;
		logic     hit_take;
		logic     out_load;
		out_sel_t out_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic in_grid;
		logic empty;
		logic cell_occ;
		logic hit;
		logic pend;
		logic n_full;
		logic k_fin;
		logic iy_last;
		logic ix_last;
		logic sweep_last;
		logic out_free;
	} dp_stat_t;

endpackage

/* src/gkaq_ifs.sv */
// Channel interfaces of the grid keypoint area query unit: request, response, config write.
// Depends on gkaq_pkg.
interface gkaq_req_if;
	import gkaq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic [LVL_W-1:0]         level;
	logic [RAD_W-1:0]         radius;
	logic [LVL_W-1:0]         min_level;
	logic signed [MAXL_W-1:0] max_level;
	modport source (output valid, func, point_x, point_y, level, radius, min_level, max_level,
		input ready);
	modport sink (input valid, func, point_x, point_y, level, radius, min_level, max_level,
		output ready);
endinterface

interface gkaq_rsp_if;
	import gkaq_pkg::*;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  key_index;
	logic              valid_res;
	logic [CIDX_W-1:0] cell_column;
	logic [CIDX_W-1:0] cell_row;
	logic              last;
	logic              truncated;
	logic              store_full;
	modport source (output valid, key_index, valid_res, cell_column, cell_row, last, truncated,
		store_full, input ready);
	modport sink (input valid, key_index, valid_res, cell_column, cell_row, last, truncated,
		store_full, output ready);
endinterface

interface gkaq_cfg_if;
	import gkaq_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/gkaq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module gkaq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end
endmodule

/* src/gkaq_dp.sv */
// Datapath: config registers, shared multiplier, cell edges, walk counters, key and cell RAMs,
// pending-hit register and the response register. Depends on gkaq_pkg, gkaq_ifs, gkaq_ram.
module gkaq_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gkaq_pkg::dp_cmd_t                cmd,
	output gkaq_pkg::dp_stat_t               stat,
	input  logic signed [gkaq_pkg::COORD_W-1:0] in_point_x,
	input  logic signed [gkaq_pkg::COORD_W-1:0] in_point_y,
	input  logic [gkaq_pkg::LVL_W-1:0]       in_level,
	input  logic [gkaq_pkg::RAD_W-1:0]       in_radius,
	input  logic [gkaq_pkg::LVL_W-1:0]       in_min_level,
	input  logic signed [gkaq_pkg::MAXL_W-1:0] in_max_level,
	gkaq_cfg_if.sink                         cfg,
	gkaq_rsp_if.source                       rsp
);
	import gkaq_pkg::*;

	localparam logic signed [EDGE_W-1:0] COL_LAST = EDGE_W'(GRID_COLUMNS - 1);
	localparam logic signed [EDGE_W-1:0] ROW_LAST = EDGE_W'(GRID_ROWS - 1);

	logic signed [COORD_W-1:0] ox_q, oy_q;
	logic [SCALE_W-1:0]        cs_q, rs_q;

	logic signed [COORD_W-1:0] px_q, py_q;
	logic [LVL_W-1:0]          lvl_q, minl_q;
	logic [RAD_W-1:0]          r_q;
	logic signed [MAXL_W-1:0]  maxl_q;

	logic [CNT_W-1:0]  key_count_q;
	logic [KEY_AW-1:0] kidx;

	logic signed [OPND_W-1:0]  dx, dy, opnd_a;
	logic signed [SCALE_W:0]   opnd_b;
	logic signed [PROD_W-1:0]  p_s1;
	logic                      p_vld_s1;
	mul_sel_t                  p_tag_s1;

	logic signed [PROD_W-1:0] ceil_sum;
	logic [PROD_W-1:0]        p_mag, rnd_sum;
	logic signed [EDGE_W-1:0] floor_v, ceil_v, rnd_mag, rnd_v;
	logic signed [EDGE_W-1:0] col_q, row_q, c0_q, c1_q, r0_q, r1_q;

	logic [CIDX_W-1:0]  ix_q, iy_q;
	logic [CELL_AW-1:0] cell_addr, sweep_q;

	logic [KEY_AW-1:0] k_q, fin_q, pend_k_q, next_rd;
	logic              pend_q;
	logic [HIT_W-1:0]  n_q;

	cell_ent_t cell_rd, cell_wdata;
	key_ent_t  key_rd, key_wdata;

	logic signed [COORD_W:0] ex, ey;
	logic [COORD_W:0]        ex_abs, ey_abs;
	logic                    lvl_ok, in_grid, out_free;

	// configuration registers, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q <= '0;
			oy_q <= '0;
			cs_q <= SCALE_W'(6554);
			rs_q <= SCALE_W'(6554);
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_ORIGIN_X:  ox_q <= cfg.data[COORD_W-1:0];
				REG_ORIGIN_Y:  oy_q <= cfg.data[COORD_W-1:0];
				REG_COL_SCALE: cs_q <= cfg.data[SCALE_W-1:0];
				REG_ROW_SCALE: rs_q <= cfg.data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q   <= in_point_x;
			py_q   <= in_point_y;
			lvl_q  <= in_level;
			r_q    <= in_radius;
			minl_q <= in_min_level;
			maxl_q <= in_max_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
		end else if (cmd.cnt_clr) begin
			key_count_q <= '0;
		end else if (cmd.cnt_inc) begin
			key_count_q <= key_count_q + 1'b1;
		end
	end
	assign kidx = key_count_q[KEY_AW-1:0];

	// shared multiplier: offset times scale, registered
	assign dx = OPND_W'(px_q) - OPND_W'(ox_q);
	assign dy = OPND_W'(py_q) - OPND_W'(oy_q);

	always_comb begin
		unique case (cmd.mul_sel)
			MS_INS_X: begin opnd_a = dx;                  opnd_b = {1'b0, cs_q}; end
			MS_INS_Y: begin opnd_a = dy;                  opnd_b = {1'b0, rs_q}; end
			MS_LO_X:  begin opnd_a = dx - OPND_W'(r_q);   opnd_b = {1'b0, cs_q}; end
			MS_HI_X:  begin opnd_a = dx + OPND_W'(r_q);   opnd_b = {1'b0, cs_q}; end
			MS_LO_Y:  begin opnd_a = dy - OPND_W'(r_q);   opnd_b = {1'b0, rs_q}; end
			MS_HI_Y:  begin opnd_a = dy + OPND_W'(r_q);   opnd_b = {1'b0, rs_q}; end
			default:  begin opnd_a = dx;                  opnd_b = {1'b0, cs_q}; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			p_s1     <= PROD_W'(opnd_a * opnd_b);
			p_tag_s1 <= cmd.mul_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_vld_s1 <= 1'b0;
		end else begin
			p_vld_s1 <= cmd.mul_en;
		end
	end

	// floor, ceiling and round half away from zero of the product
	always_comb begin
		floor_v  = p_s1[FRAC_BITS +: EDGE_W];
		ceil_sum = p_s1 + $signed(FRAC_MASK);
		ceil_v   = ceil_sum[FRAC_BITS +: EDGE_W];
		p_mag    = p_s1[PROD_W-1] ? PROD_W'(-p_s1) : PROD_W'(p_s1);
		rnd_sum  = p_mag + FRAC_HALF;
		rnd_mag  = rnd_sum[FRAC_BITS +: EDGE_W];
		rnd_v    = p_s1[PROD_W-1] ? -rnd_mag : rnd_mag;
	end

	always_ff @(posedge clk) begin
		if (p_vld_s1) begin
			unique case (p_tag_s1)
				MS_INS_X: col_q <= rnd_v;
				MS_INS_Y: row_q <= rnd_v;
				MS_LO_X:  c0_q  <= floor_v[EDGE_W-1] ? '0 : floor_v;
				MS_HI_X:  c1_q  <= (ceil_v > COL_LAST) ? COL_LAST : ceil_v;
				MS_LO_Y:  r0_q  <= floor_v[EDGE_W-1] ? '0 : floor_v;
				MS_HI_Y:  r1_q  <= (ceil_v > ROW_LAST) ? ROW_LAST : ceil_v;
				default: ;
			endcase
		end
	end

	assign in_grid = !col_q[EDGE_W-1] && (col_q <= COL_LAST)
		&& !row_q[EDGE_W-1] && (row_q <= ROW_LAST);

	// cell walk counters
	always_ff @(posedge clk) begin
		if (cmd.ins_load_ix) begin
			ix_q <= col_q[CIDX_W-1:0];
			iy_q <= row_q[CIDX_W-1:0];
		end else if (cmd.q_load_start) begin
			ix_q <= c0_q[CIDX_W-1:0];
			iy_q <= r0_q[CIDX_W-1:0];
		end else if (cmd.ix_inc) begin
			ix_q <= ix_q + 1'b1;
			iy_q <= r0_q[CIDX_W-1:0];
		end else if (cmd.iy_inc) begin
			iy_q <= iy_q + 1'b1;
		end
	end

	assign cell_addr = CELL_AW'(32'(ix_q) * GRID_ROWS + 32'(iy_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_wr) begin
			sweep_q <= (sweep_q == CELL_AW'(NUM_CELLS - 1)) ? '0 : sweep_q + 1'b1;
		end
	end

	// cell list heads and tails
	always_comb begin
		cell_wdata = '0;
		if (!cmd.sweep_wr) begin
			cell_wdata.occ   = 1'b1;
			cell_wdata.first = cell_rd.occ ? cell_rd.first : kidx;
			cell_wdata.tail  = kidx;
		end
	end

	gkaq_ram #(.WIDTH($bits(cell_ent_t)), .DEPTH(NUM_CELLS)) u_cell_ram (
		.clk     (clk),
		.we      (cmd.sweep_wr || cmd.cell_ins_wr),
		.waddr   (cmd.sweep_wr ? sweep_q : cell_addr),
		.wdata   (cell_wdata),
		.re      (cmd.cell_rd),
		.raddr   (cell_addr),
		.rdata_q (cell_rd)
	);

	assign key_wdata = '{x: px_q, y: py_q, lvl: lvl_q};

	gkaq_ram #(.WIDTH($bits(key_ent_t)), .DEPTH(MAX_KEYS)) u_key_ram (
		.clk     (clk),
		.we      (cmd.key_wr),
		.waddr   (kidx),
		.wdata   (key_wdata),
		.re      (cmd.key_rd),
		.raddr   (k_q),
		.rdata_q (key_rd)
	);

	gkaq_ram #(.WIDTH(KEY_AW), .DEPTH(MAX_KEYS)) u_next_ram (
		.clk     (clk),
		.we      (cmd.cell_ins_wr && cell_rd.occ),
		.waddr   (cell_rd.tail),
		.wdata   (kidx),
		.re      (cmd.key_rd),
		.raddr   (k_q),
		.rdata_q (next_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.k_load_first) begin
			k_q   <= cell_rd.first;
			fin_q <= cell_rd.tail;
		end else if (cmd.k_load_next) begin
			k_q <= next_rd;
		end
	end

	// hit test of the key just read
	always_comb begin
		ex     = (COORD_W+1)'(key_rd.x) - (COORD_W+1)'(px_q);
		ey     = (COORD_W+1)'(key_rd.y) - (COORD_W+1)'(py_q);
		ex_abs = ex[COORD_W] ? (COORD_W+1)'(-ex) : (COORD_W+1)'(ex);
		ey_abs = ey[COORD_W] ? (COORD_W+1)'(-ey) : (COORD_W+1)'(ey);
		lvl_ok = (key_rd.lvl >= minl_q)
			&& (maxl_q[MAXL_W-1] || ({1'b0, key_rd.lvl} <= maxl_q[LVL_W:0]));
	end

	// one hit held back so the final one can carry last and truncated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			n_q    <= '0;
		end else if (cmd.hit_rst) begin
			pend_q <= 1'b0;
			n_q    <= '0;
		end else if (cmd.hit_take) begin
			pend_q <= 1'b1;
			n_q    <= n_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hit_take) begin
			pend_k_q <= k_q;
		end
	end

	// response register
	assign out_free = !rsp.valid || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (cmd.out_load) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp.key_index   <= '0;
			rsp.valid_res   <= 1'b0;
			rsp.cell_column <= '0;
			rsp.cell_row    <= '0;
			rsp.last        <= 1'b1;
			rsp.truncated   <= 1'b0;
			rsp.store_full  <= 1'b0;
			unique case (cmd.out_sel)
				OS_PLAIN: ;
				OS_FULL:  rsp.store_full <= 1'b1;
				OS_INSERT: begin
					rsp.key_index   <= IDX_W'(kidx);
					rsp.valid_res   <= in_grid;
					rsp.cell_column <= in_grid ? col_q[CIDX_W-1:0] : '0;
					rsp.cell_row    <= in_grid ? row_q[CIDX_W-1:0] : '0;
				end
				OS_HIT: begin
					rsp.key_index <= IDX_W'(pend_k_q);
					rsp.valid_res <= 1'b1;
					rsp.last      <= 1'b0;
				end
				OS_HIT_LAST: begin
					rsp.key_index <= IDX_W'(pend_k_q);
					rsp.valid_res <= 1'b1;
				end
				OS_HIT_TRUNC: begin
					rsp.key_index <= IDX_W'(pend_k_q);
					rsp.valid_res <= 1'b1;
					rsp.truncated <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		stat.full       = key_count_q >= CNT_W'(MAX_KEYS);
		stat.in_grid    = in_grid;
		stat.empty      = (c0_q > c1_q) || (r0_q > r1_q);
		stat.cell_occ   = cell_rd.occ;
		stat.hit        = lvl_ok && (ex_abs < (COORD_W+1)'(r_q)) && (ey_abs < (COORD_W+1)'(r_q));
		stat.pend       = pend_q;
		stat.n_full     = n_q == HIT_W'(MAX_HITS);
		stat.k_fin      = k_q == fin_q;
		stat.iy_last    = iy_q == r1_q[CIDX_W-1:0];
		stat.ix_last    = ix_q == c1_q[CIDX_W-1:0];
		stat.sweep_last = sweep_q == CELL_AW'(NUM_CELLS - 1);
		stat.out_free   = out_free;
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free) else $error("response loaded over an untaken result");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= CNT_W'(MAX_KEYS)) else $error("key count beyond store size");
	a_hit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit_take |-> n_q < HIT_W'(MAX_HITS)) else $error("hit taken past the cap");
	a_ins_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> key_count_q < CNT_W'(MAX_KEYS)) else $error("insert into full store");
endmodule

/* src/gkaq_ctrl.sv */
// Controller state machine: sequences clear sweep, insert and query walk over the datapath.
// Depends on gkaq_pkg.
module gkaq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  gkaq_pkg::func_t    in_func,
	output logic               in_ready,
	output gkaq_pkg::dp_cmd_t  cmd,
	input  gkaq_pkg::dp_stat_t stat
);
	import gkaq_pkg::*;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SWEEP, S_MUL, S_DRAIN, S_INS_CHK, S_INS_RD, S_INS_WR,
		S_Q_START, S_C_RD, S_C_CHK, S_K_RD, S_K_CHK, S_NEXT_C, S_Q_END, S_RESP
	} state_t;

	state_t   state_q, state_d;
	logic [1:0] mstep_q, mstep_d;
	logic     is_query_q, is_query_d;
	out_sel_t osel_q, osel_d;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		mstep_d    = mstep_q;
		is_query_d = is_query_q;
		osel_d     = osel_q;
		in_ready   = state_q == S_IDLE;

		unique case (state_q)
			S_INIT: begin
				cmd.sweep_wr = 1'b1;
				if (stat.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					mstep_d     = '0;
					unique case (in_func)
						FN_CLEAR: begin
							cmd.cnt_clr = 1'b1;
							state_d     = S_SWEEP;
						end
						FN_INSERT: begin
							is_query_d = 1'b0;
							if (stat.full) begin
								osel_d  = OS_FULL;
								state_d = S_RESP;
							end else begin
								state_d = S_MUL;
							end
						end
						FN_QUERY: begin
							is_query_d  = 1'b1;
							cmd.hit_rst = 1'b1;
							state_d     = S_MUL;
						end
						FN_NONE: begin
							osel_d  = OS_PLAIN;
							state_d = S_RESP;
						end
						default: ;
					endcase
				end
			end
			S_SWEEP: begin
				cmd.sweep_wr = 1'b1;
				if (stat.sweep_last) begin
					osel_d  = OS_PLAIN;
					state_d = S_RESP;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				mstep_d    = mstep_q + 1'b1;
				if (is_query_q) begin
					unique case (mstep_q)
						2'd0: cmd.mul_sel = MS_LO_X;
						2'd1: cmd.mul_sel = MS_HI_X;
						2'd2: cmd.mul_sel = MS_LO_Y;
						2'd3: cmd.mul_sel = MS_HI_Y;
						default: ;
					endcase
					if (mstep_q == 2'd3) state_d = S_DRAIN;
				end else begin
					cmd.mul_sel = mstep_q[0] ? MS_INS_Y : MS_INS_X;
					if (mstep_q[0]) state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = is_query_q ? S_Q_START : S_INS_CHK;
			S_INS_CHK: begin
				osel_d = OS_INSERT;
				if (stat.in_grid) begin
					cmd.ins_load_ix = 1'b1;
					state_d         = S_INS_RD;
				end else begin
					state_d = S_RESP;
				end
			end
			S_INS_RD: begin
				cmd.cell_rd = 1'b1;
				state_d     = S_INS_WR;
			end
			S_INS_WR: begin
				cmd.cell_ins_wr = 1'b1;
				state_d         = S_RESP;
			end
			S_Q_START: begin
				if (stat.empty) begin
					state_d = S_Q_END;
				end else begin
					cmd.q_load_start = 1'b1;
					state_d          = S_C_RD;
				end
			end
			S_C_RD: begin
				cmd.cell_rd = 1'b1;
				state_d     = S_C_CHK;
			end
			S_C_CHK: begin
				if (stat.cell_occ) begin
					cmd.k_load_first = 1'b1;
					state_d          = S_K_RD;
				end else begin
					state_d = S_NEXT_C;
				end
			end
			S_K_RD: begin
				cmd.key_rd = 1'b1;
				state_d    = S_K_CHK;
			end
			S_K_CHK: begin
				priority if (stat.hit && stat.pend && stat.n_full) begin
					// one more hit than the cap: close with the held hit
					if (stat.out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_sel  = OS_HIT_TRUNC;
						state_d      = S_IDLE;
					end
				end else if (stat.hit && stat.pend && !stat.out_free) begin
					// hold until the response register frees
				end else begin
					if (stat.hit) begin
						cmd.hit_take = 1'b1;
						if (stat.pend) begin
							cmd.out_load = 1'b1;
							cmd.out_sel  = OS_HIT;
						end
					end
					if (stat.k_fin) begin
						state_d = S_NEXT_C;
					end else begin
						cmd.k_load_next = 1'b1;
						state_d         = S_K_RD;
					end
				end
			end
			S_NEXT_C: begin
				if (stat.iy_last) begin
					if (stat.ix_last) begin
						state_d = S_Q_END;
					end else begin
						cmd.ix_inc = 1'b1;
						state_d    = S_C_RD;
					end
				end else begin
					cmd.iy_inc = 1'b1;
					state_d    = S_C_RD;
				end
			end
			S_Q_END: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = stat.pend ? OS_HIT_LAST : OS_PLAIN;
					state_d      = S_IDLE;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = osel_q;
					if (osel_q == OS_INSERT) begin
						cmd.cnt_inc = 1'b1;
						cmd.key_wr  = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			mstep_q    <= '0;
			is_query_q <= 1'b0;
			osel_q     <= OS_PLAIN;
		end else begin
			state_q    <= state_d;
			mstep_q    <= mstep_d;
			is_query_q <= is_query_d;
			osel_q     <= osel_d;
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.out_load) else $error("result loaded while taking a new item");
	a_walk_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_K_CHK && !cmd.k_load_next && state_d == S_K_CHK) |=> $stable(osel_q))
		else $error("response select moved during a stalled hit");
	a_sweep_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_wr |-> !in_ready) else $error("item accepted during cell sweep");
endmodule

/* src/grid_keypoint_area_query_unit.sv */
// Top level of the grid keypoint area query unit.
// Throughput: one item at a time; the next item is taken after the last result is loaded.
// Query time is set by the cell walk and the single key RAM read port; each key is read, then checked.
// Reset: config registers take their reset values; a sweep over all 3072 cells clears the cell
// table, with req.ready low throughout. Config writes are taken at any time.
module grid_keypoint_area_query_unit (
	input logic        clk,
	input logic        arst_n,
	gkaq_req_if.sink   req,
	gkaq_rsp_if.source rsp,
	gkaq_cfg_if.sink   cfg
);
	import gkaq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     ctrl_ready;

	// transfer on req only while the controller is idle
	assign req.ready = ctrl_ready;

	gkaq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_func  (func_t'(req.func)),
		.in_ready (ctrl_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	gkaq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_point_x   (req.point_x),
		.in_point_y   (req.point_y),
		.in_level     (req.level),
		.in_radius    (req.radius),
		.in_min_level (req.min_level),
		.in_max_level (req.max_level),
		.cfg          (cfg),
		.rsp          (rsp)
	);
endmodule
